// File: hw/rtl/ppp_pkg.sv
// Package for point_to_pixel_projection: types, constants and register codes.
package ppp_pkg;

   // Field widths
   localparam int COORD_W    = 32;
   localparam int CFG_W      = 32;
   localparam int SCALE_W    = 15;
   localparam int ROW_W      = 11;
   localparam int COL_W      = 12;
   localparam int IDX_W      = 19;
   localparam int CSR_IDX_W  = 3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_COL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_ROW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_SCALE = 3'd4;

   // Register reset values
   localparam logic [CFG_W-1:0]   FOCAL_X_RST     = 32'd34603008;
   localparam logic [CFG_W-1:0]   FOCAL_Y_RST     = 32'd34603008;
   localparam logic [CFG_W-1:0]   CENTER_COL_RST  = 32'd20971520;
   localparam logic [CFG_W-1:0]   CENTER_ROW_RST  = 32'd15728640;
   localparam logic [SCALE_W-1:0] IMAGE_SCALE_RST = 15'd4096;

   // Parameter defaults
   localparam int MAX_POINTS_DEF  = 524288;
   localparam int BASE_WIDTH_DEF  = 640;
   localparam int BASE_HEIGHT_DEF = 480;
   localparam int BASE_W          = 13;

   // Image size caps and scale fraction
   localparam int COL_CAP    = 4096;
   localparam int ROW_CAP    = 2048;
   localparam int DIMC_W     = 13;
   localparam int DIMR_W     = 12;
   localparam int SCALE_FRAC = 12;
   localparam int SIZE_PROD_W = BASE_W + SCALE_W;
   localparam int IDX_FIELD_MAX = 2**IDX_W - 1;

   // Projection arithmetic
   localparam int PROD_W    = 2 * COORD_W;
   localparam int QUO_W     = 48;
   localparam int REM_W     = 32;
   localparam int DIV_BITS  = 3;
   localparam int DIV_CYCLES = QUO_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_CYCLES);
   localparam int SUM_W     = QUO_W + 2;
   localparam int T_W       = SUM_W + SCALE_W + 1;
   localparam int RND_SHIFT = 28;
   localparam int PIX_W     = T_W - RND_SHIFT;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_INIT,
      ST_DIV,
      ST_ADD,
      ST_SCL,
      ST_RND,
      ST_DONE
   } ppp_state_type;

   typedef struct packed {
      logic take;
      logic mul;
      logic div_init;
      logic div_step;
      logic add;
      logic scale;
      logic round;
      logic out_load;
      logic axis;
   } ppp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic zero;
      logic out_free;
   } ppp_stat_type;

endpackage

// File: hw/rtl/ppp_if.sv
// Channel interfaces for requests, results and register writes.
interface ppp_req_if import ppp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;
   logic                      last_point;

   modport source (output valid, point_x, point_y, point_z, last_point, input ready);
   modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface ppp_rsp_if import ppp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] pixel_row;
   logic [COL_W-1:0] pixel_col;
   logic [IDX_W-1:0] point_index;
   logic             zero_depth;
   logic             last_out;

   modport source (output valid, pixel_row, pixel_col, point_index, zero_depth, last_out,
                   input ready);
   modport sink (input valid, pixel_row, pixel_col, point_index, zero_depth, last_out,
                 output ready);
endinterface

interface ppp_csr_if import ppp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/ppp_ctrl.sv
// Controller state machine sequencing the projection datapath.
module ppp_ctrl import ppp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ppp_stat_type stat,
   output ppp_cmd_type  cmd
);

   ppp_state_type        state_ff, state_in;
   logic                 axis_ff, axis_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 div_last;

   assign div_last = (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1));

   // Hold state, axis and divider step count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            axis_in = 1'b0;
            if (stat.req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = stat.zero ? ST_DONE : ST_INIT;
         end
         ST_INIT: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = ST_SCL;
         end
         ST_SCL: begin
            state_in = ST_RND;
         end
         ST_RND: begin
            axis_in  = 1'b1;
            state_in = axis_ff ? ST_DONE : ST_MUL;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd      = '0;
      cmd.axis = axis_ff;
      case (state_ff)
         ST_IDLE: cmd.take     = 1'b1;
         ST_MUL:  cmd.mul      = 1'b1;
         ST_INIT: cmd.div_init = 1'b1;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_ADD:  cmd.add      = 1'b1;
         ST_SCL:  cmd.scale    = 1'b1;
         ST_RND:  cmd.round    = 1'b1;
         ST_DONE: cmd.out_load = stat.out_free;
         default: cmd.take     = 1'b0;
      endcase
   end

endmodule

// File: hw/rtl/ppp_dp.sv
// Projection datapath: registers, multiplier, shared divider, rounding and result register.
module ppp_dp import ppp_pkg::*; #(
   parameter int MAX_POINTS  = MAX_POINTS_DEF,
   parameter int BASE_WIDTH  = BASE_WIDTH_DEF,
   parameter int BASE_HEIGHT = BASE_HEIGHT_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  ppp_cmd_type  cmd,
   output ppp_stat_type stat,
   ppp_req_if.sink      req,
   ppp_rsp_if.source    rsp,
   ppp_csr_if.sink      csr
);

   localparam int IDX_LIMIT_INT = (MAX_POINTS - 1 < IDX_FIELD_MAX) ? MAX_POINTS - 1
                                                                     : IDX_FIELD_MAX;
   localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(IDX_LIMIT_INT);
   localparam logic [QUO_W-1:0] P_SAT     = QUO_W'(1) << (QUO_W - 1);

   // Configuration registers
   logic [CFG_W-1:0]   focal_x_ff, focal_y_ff, center_col_ff, center_row_ff;
   logic [SCALE_W-1:0] scale_ff;

   // Captured request
   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic [COORD_W-1:0]        z_mag_ff;
   logic                      z_neg_ff, zero_ff, last_ff;

   // Working registers
   logic [PROD_W-1:0]       prod_ff;
   logic                    sign_ff, sat_ff;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic signed [T_W-1:0]   t_ff;
   logic [COL_W-1:0]        col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [DIMC_W-1:0]       dim_col_ff;
   logic [DIMR_W-1:0]       dim_row_ff;

   // Result register and running index
   logic             rsp_valid_ff;
   logic [ROW_W-1:0] row_out_ff;
   logic [COL_W-1:0] col_out_ff;
   logic [IDX_W-1:0] idx_out_ff;
   logic             zero_out_ff, last_out_ff;
   logic [IDX_W-1:0] index_ff;

   logic                    load_in;
   logic signed [COORD_W-1:0] coord_sel;
   logic [COORD_W-1:0]      c_mag, z_mag;
   logic [CFG_W-1:0]        focal_sel, center_sel;
   logic [SIZE_PROD_W-1:0]  wprod, hprod;
   logic [SIZE_PROD_W-SCALE_FRAC-1:0] wq, hq;
   logic [QUO_W-1:0]        mag;
   logic signed [T_W-1:0]   t_in;
   logic [T_W-1:0]          t_rnd;
   logic [PIX_W-1:0]        vpix;
   logic [DIMC_W-1:0]       dim_sel, pix;

   assign load_in = cmd.take && req.valid;

   // Status and handshakes; nothing is taken while in reset
   assign req.ready      = cmd.take && !reset;
   assign csr.ready      = !reset;
   assign stat.req_valid = req.valid;
   assign stat.zero      = zero_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp.ready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff    <= FOCAL_X_RST;
         focal_y_ff    <= FOCAL_Y_RST;
         center_col_ff <= CENTER_COL_RST;
         center_row_ff <= CENTER_ROW_RST;
         scale_ff      <= IMAGE_SCALE_RST;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_FOCAL_X:     focal_x_ff    <= csr.data;
            CSR_FOCAL_Y:     focal_y_ff    <= csr.data;
            CSR_CENTER_COL:  center_col_ff <= csr.data;
            CSR_CENTER_ROW:  center_row_ff <= csr.data;
            CSR_IMAGE_SCALE: scale_ff      <= csr.data[SCALE_W-1:0];
            default:         scale_ff      <= scale_ff;
         endcase
      end
   end

   // Image sizes from the scale, capped to the output fields
   assign wprod = SIZE_PROD_W'(BASE_WIDTH) * SIZE_PROD_W'(scale_ff);
   assign hprod = SIZE_PROD_W'(BASE_HEIGHT) * SIZE_PROD_W'(scale_ff);
   assign wq    = wprod[SIZE_PROD_W-1:SCALE_FRAC];
   assign hq    = hprod[SIZE_PROD_W-1:SCALE_FRAC];

   always_ff @(posedge clock) begin
      dim_col_ff <= (wq > (SIZE_PROD_W-SCALE_FRAC)'(COL_CAP)) ? DIMC_W'(COL_CAP)
                                                            : wq[DIMC_W-1:0];
      dim_row_ff <= (hq > (SIZE_PROD_W-SCALE_FRAC)'(ROW_CAP)) ? DIMR_W'(ROW_CAP)
                                                            : hq[DIMR_W-1:0];
   end

   // Operand selection by axis
   assign z_mag      = req.point_z[COORD_W-1] ? (~req.point_z + 1'b1) : req.point_z;
   assign coord_sel  = cmd.axis ? y_ff : x_ff;
   assign c_mag      = coord_sel[COORD_W-1] ? COORD_W'(~coord_sel + 1'b1) : coord_sel;
   assign focal_sel  = cmd.axis ? focal_y_ff : focal_x_ff;
   assign center_sel = cmd.axis ? center_row_ff : center_col_ff;
   assign dim_sel    = cmd.axis ? DIMC_W'(dim_row_ff) : dim_col_ff;

   // Three quotient bits a cycle, restoring
   always_comb begin
      logic [REM_W:0] trial;
      rem_in = rem_ff;
      quo_in = quo_ff;
      trial  = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial  = {rem_in, quo_in[QUO_W-1]};
         quo_in = {quo_in[QUO_W-2:0], 1'b0};
         if (trial >= {1'b0, z_mag_ff}) begin
            trial     = trial - {1'b0, z_mag_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = trial[REM_W-1:0];
      end
   end

   // Saturate, apply sign, add principal point, scale by the image scale
   assign mag    = (sat_ff || quo_ff > P_SAT) ? P_SAT : quo_ff;
   assign sum_in = (sign_ff ? (~{2'b00, mag} + 1'b1) : {2'b00, mag})
                   + SUM_W'(center_sel);
   assign t_in   = $signed(sum_ff) * $signed({1'b0, scale_ff});

   // Round half up and clamp into the image
   assign t_rnd = t_ff + (T_W'(1) << (RND_SHIFT - 1));
   assign vpix  = t_rnd[T_W-1:RND_SHIFT];
   always_comb begin
      if (dim_sel == '0 || t_ff[T_W-1]) begin
         pix = '0;
      end else if (vpix >= PIX_W'(dim_sel)) begin
         pix = dim_sel - 1'b1;
      end else begin
         pix = vpix[DIMC_W-1:0];
      end
   end

   // Advance the datapath registers
   always_ff @(posedge clock) begin
      if (load_in) begin
         x_ff     <= req.point_x;
         y_ff     <= req.point_y;
         z_mag_ff <= z_mag;
         z_neg_ff <= req.point_z[COORD_W-1];
         zero_ff  <= (req.point_z == '0);
         last_ff  <= req.last_point;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(c_mag) * PROD_W'(focal_sel);
         sign_ff <= coord_sel[COORD_W-1] ^ z_neg_ff;
      end
      if (cmd.div_init) begin
         rem_ff <= REM_W'(prod_ff[PROD_W-2:QUO_W]);
         quo_ff <= prod_ff[QUO_W-1:0];
         sat_ff <= (REM_W'(prod_ff[PROD_W-2:QUO_W]) >= z_mag_ff);
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.add) begin
         sum_ff <= sum_in;
      end
      if (cmd.scale) begin
         t_ff <= t_in;
      end
      if (cmd.round) begin
         if (cmd.axis) begin
            row_ff <= pix[ROW_W-1:0];
         end else begin
            col_ff <= pix[COL_W-1:0];
         end
      end
   end

   // Result register and point index
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         index_ff     <= '0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
            if (last_ff) begin
               index_ff <= '0;
            end else if (index_ff < IDX_LIMIT) begin
               index_ff <= index_ff + 1'b1;
            end
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         row_out_ff  <= zero_ff ? '0 : row_ff;
         col_out_ff  <= zero_ff ? '0 : col_ff;
         idx_out_ff  <= index_ff;
         zero_out_ff <= zero_ff;
         last_out_ff <= last_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_row   = row_out_ff;
   assign rsp.pixel_col   = col_out_ff;
   assign rsp.point_index = idx_out_ff;
   assign rsp.zero_depth  = zero_out_ff;
   assign rsp.last_out    = last_out_ff;

endmodule

// File: hw/rtl/point_to_pixel_projection.sv
// Top level of the point to pixel projection block.
//
//  channel  | role   | payload
//  ---------+--------+---------------------------------------------------
//  req_bus  | in     | point_x, point_y, point_z (Q16.16), last_point
//  rsp_bus  | out    | pixel_row, pixel_col, point_index, zero_depth, last_out
//  csr_bus  | in     | index, data (focal_x .. image_scale), ready outside reset
//
//  A request is projected one axis at a time, column then row, each through the
//  shared 3-bit-per-cycle divider; a zero-depth request skips both axes.
//  Reset is synchronous: it clears the state machine, the result valid and the
//  point index and loads the register defaults.
//  A finished result waits in the output register; the next request is taken
//  meanwhile and holds at its end until that register is free.
module point_to_pixel_projection import ppp_pkg::*; #(
   parameter int MAX_POINTS  = MAX_POINTS_DEF,
   parameter int BASE_WIDTH  = BASE_WIDTH_DEF,
   parameter int BASE_HEIGHT = BASE_HEIGHT_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ppp_req_if.sink   req_bus,
   ppp_rsp_if.source rsp_bus,
   ppp_csr_if.sink   csr_bus
);

   ppp_cmd_type  cmd;
   ppp_stat_type stat;

   ppp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   ppp_dp #(
      .MAX_POINTS  (MAX_POINTS),
      .BASE_WIDTH  (BASE_WIDTH),
      .BASE_HEIGHT (BASE_HEIGHT)
   ) u_dp (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

endmodule

// File: hw/rtl/ppp_checker.sv
// Port checker for point_to_pixel_projection and its bind.
module ppp_checker import ppp_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [ROW_W-1:0] pixel_row,
   input logic [COL_W-1:0] pixel_col,
   input logic [IDX_W-1:0] point_index,
   input logic             zero_depth,
   input logic             last_out
);

   logic [1:0] outst_ff;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Count requests taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else if (req_acc && !rsp_acc) begin
         outst_ff <= outst_ff + 1'b1;
      end else if (rsp_acc && !req_acc) begin
         outst_ff <= outst_ff - 1'b1;
      end
   end

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_row) && $stable(pixel_col)
         && $stable(point_index) && $stable(zero_depth) && $stable(last_out))
      else $error("result changed while stalled");

   // Zero depth forces the origin
   a_zero_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && zero_depth |-> pixel_row == '0 && pixel_col == '0)
      else $error("zero depth result not at origin");

   // No result without a request behind it
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outst_ff != 2'd0)
      else $error("result without request");

   // At most one request in work besides a waiting result
   a_depth: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> outst_ff == 2'd0 || (outst_ff == 2'd1 && rsp_valid))
      else $error("request taken while another is in work");

endmodule

bind point_to_pixel_projection ppp_checker u_ppp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .pixel_row   (rsp_bus.pixel_row),
   .pixel_col   (rsp_bus.pixel_col),
   .point_index (rsp_bus.point_index),
   .zero_depth  (rsp_bus.zero_depth),
   .last_out    (rsp_bus.last_out)
);

// File: verif/point_to_pixel_projection_tb.sv
// Self-checking testbench for point_to_pixel_projection with a pixel scoreboard.
`timescale 1ns / 100ps

module point_to_pixel_projection_tb import ppp_pkg::*; ();

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      last;
   } cloud_point_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [IDX_W-1:0] index;
      logic             zero;
      logic             last;
   } pixel_type;

   // Projects each request and holds the pixels still owed by the block.
   class pixel_scoreboard;
      logic [CFG_W-1:0]   focal_x;
      logic [CFG_W-1:0]   focal_y;
      logic [CFG_W-1:0]   center_col;
      logic [CFG_W-1:0]   center_row;
      logic [SCALE_W-1:0] image_scale;
      logic [IDX_W-1:0]   next_index;
      pixel_type          expected_pixels[$];
      int                 failures;

      function new();
         focal_x     = FOCAL_X_RST;
         focal_y     = FOCAL_Y_RST;
         center_col  = CENTER_COL_RST;
         center_row  = CENTER_ROW_RST;
         image_scale = IMAGE_SCALE_RST;
         next_index  = '0;
         failures    = 0;
      endfunction

      function int outstanding();
         return expected_pixels.size();
      endfunction

      // Mirror a register write; unknown indexes are dropped.
      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            CSR_FOCAL_X:     focal_x = data;
            CSR_FOCAL_Y:     focal_y = data;
            CSR_CENTER_COL:  center_col = data;
            CSR_CENTER_ROW:  center_row = data;
            CSR_IMAGE_SCALE: image_scale = data[SCALE_W-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned image_size(int base, int cap);
         longint unsigned d;
         d = (longint'(base) * image_scale) >> SCALE_FRAC;
         return (d > cap) ? longint'(cap) : d;
      endfunction

      // One axis: divide, offset by the principal point, scale, round half up, clamp.
      function longint unsigned project_axis(logic [COORD_W-1:0] c, logic [63:0] zmag,
                                             bit zneg, logic [CFG_W-1:0] focal,
                                             logic [CFG_W-1:0] center,
                                             longint unsigned size);
         bit          cneg;
         logic [63:0] cmag;
         logic [63:0] mag;
         longint      p;
         longint      t;
         logic [63:0] v;
         cneg = c[COORD_W-1];
         cmag = {32'b0, cneg ? (~c + 32'd1) : c};
         mag  = (cmag * {32'b0, focal}) / zmag;
         if (mag > (64'd1 << 47))
            mag = 64'd1 << 47;
         p = (cneg != zneg) ? -signed'(mag) : signed'(mag);
         t = (p + signed'({32'b0, center})) * signed'({49'b0, image_scale});
         if (size == 0 || t < 0)
            return 0;
         v = (unsigned'(t) + (64'd1 << 27)) >> 28;
         return (v >= size) ? size - 1 : v;
      endfunction

      // Work out the pixel for an accepted request and advance the point index.
      function void note_point(cloud_point_type pt);
         pixel_type        px;
         logic [63:0]      zmag;
         bit               zneg;
         longint unsigned  w;
         longint unsigned  h;
         logic [IDX_W-1:0] limit;
         zneg = pt.z[COORD_W-1];
         zmag = {32'b0, zneg ? (~pt.z + 32'd1) : pt.z};
         px = '0;
         if (zmag == 0) begin
            px.zero = 1'b1;
         end else begin
            w = image_size(BASE_WIDTH_DEF, COL_CAP);
            h = image_size(BASE_HEIGHT_DEF, ROW_CAP);
            px.col = COL_W'(project_axis(pt.x, zmag, zneg, focal_x, center_col, w));
            px.row = ROW_W'(project_axis(pt.y, zmag, zneg, focal_y, center_row, h));
         end
         px.index = next_index;
         px.last  = pt.last;
         limit = (MAX_POINTS_DEF - 1 < IDX_FIELD_MAX) ? IDX_W'(MAX_POINTS_DEF - 1)
                                                      : IDX_W'(IDX_FIELD_MAX);
         if (pt.last)
            next_index = '0;
         else if (next_index < limit)
            next_index = next_index + 1'b1;
         expected_pixels.insert(expected_pixels.size(), px);
      endfunction

      // Compare a returned pixel with the oldest one owed.
      function void check_pixel(pixel_type got);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected pixel: row %0d col %0d index %0d zero %0b last %0b",
                        got.row, got.col, got.index, got.zero, got.last);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.row !== want.row || got.col !== want.col || got.index !== want.index ||
             got.zero !== want.zero || got.last !== want.last) begin
            failures++;
            if (failures <= 10)
               $display("pixel mismatch: expected row %0d col %0d index %0d zero %0b last %0b, %s",
                        want.row, want.col, want.index, want.zero, want.last,
                        $sformatf("got row %0d col %0d index %0d zero %0b last %0b",
                                  got.row, got.col, got.index, got.zero, got.last));
         end
      endfunction
   endclass

   localparam logic signed [COORD_W-1:0] Q_ONE  = 32'sh0001_0000;
   localparam logic signed [COORD_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] Q_MIN  = 32'sh8000_0000;
   localparam int                        PHASES = 8;
   localparam int                        PHASE_POINTS = 220;

   typedef struct {
      logic [CFG_W-1:0] fx;
      logic [CFG_W-1:0] fy;
      logic [CFG_W-1:0] cc;
      logic [CFG_W-1:0] cr;
      logic [CFG_W-1:0] sc;
   } camera_setting_type;

   logic clock;
   logic reset;
   bit   req_idling;
   bit   rsp_idling;
   bit   hold_rsp;

   pixel_scoreboard board = new();

   ppp_req_if req_bus();
   ppp_rsp_if rsp_bus();
   ppp_csr_if csr_bus();

   point_to_pixel_projection dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Check every pixel taken from the block.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_pixel({rsp_bus.pixel_row, rsp_bus.pixel_col, rsp_bus.point_index,
                            rsp_bus.zero_depth, rsp_bus.last_out});
   end

   // Result side: random stalls per pixel, plus one long hold-off on request.
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         gap = rsp_idling ? $urandom_range(0, 3) : 0;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic cloud_point_type make_point(logic signed [COORD_W-1:0] x,
                                                  logic signed [COORD_W-1:0] y,
                                                  logic signed [COORD_W-1:0] z,
                                                  logic last);
      cloud_point_type pt;
      pt.x = x;
      pt.y = y;
      pt.z = z;
      pt.last = last;
      return pt;
   endfunction

   // Mostly points in front of the camera, some near the lens, noise, zero depth and behind the camera.
   function automatic cloud_point_type random_point();
      cloud_point_type pt;
      int              depth;
      int              kind;
      kind  = $urandom_range(0, 99);
      depth = int'($urandom_range(32'h0000_8000, 32'h0014_0000));
      pt.x  = int'($urandom_range(0, 2 * depth)) - depth;
      pt.y  = int'($urandom_range(0, 2 * depth)) - depth;
      pt.z  = depth;
      if (kind >= 70 && kind < 78) begin
         pt.x = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         pt.y = int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         pt.z = int'($urandom_range(1, 255));
      end else if (kind >= 78 && kind < 88) begin
         pt.x = $urandom;
         pt.y = $urandom;
         pt.z = $urandom;
      end else if (kind >= 88 && kind < 94) begin
         pt.x = $urandom;
         pt.y = $urandom;
         pt.z = '0;
      end else if (kind >= 94) begin
         pt.z = -depth;
      end
      pt.last = ($urandom_range(0, 39) == 0);
      return pt;
   endfunction

   // Offer one request; valid stays high across back-to-back requests.
   task automatic send_point(cloud_point_type pt);
      int gap;
      gap = req_idling ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.point_x    <= pt.x;
      req_bus.point_y    <= pt.y;
      req_bus.point_z    <= pt.z;
      req_bus.last_point <= pt.last;
      do @(posedge clock); while (!req_bus.ready);
      board.note_point(pt);
   endtask

   // Drop valid and hold until every pixel owed has come back.
   task automatic end_burst();
      req_bus.valid <= 1'b0;
      while (board.outstanding() != 0)
         @(posedge clock);
   endtask

   // Write all registers, then junk to the unused indexes, which must be ignored.
   task automatic apply_setting(camera_setting_type s);
      logic [CFG_W-1:0] data [2**CSR_IDX_W];
      foreach (data[i])
         data[i] = $urandom;
      data[CSR_FOCAL_X]     = s.fx;
      data[CSR_FOCAL_Y]     = s.fy;
      data[CSR_CENTER_COL]  = s.cc;
      data[CSR_CENTER_ROW]  = s.cr;
      data[CSR_IMAGE_SCALE] = s.sc;
      for (int i = 0; i < 2**CSR_IDX_W; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= CSR_IDX_W'(i);
         csr_bus.data  <= data[i];
         do @(posedge clock); while (!csr_bus.ready);
         board.write_register(CSR_IDX_W'(i), data[i]);
      end
      csr_bus.valid <= 1'b0;
   endtask

   function automatic camera_setting_type pick_setting(int phase);
      camera_setting_type s;
      // nominal camera, scale written with junk above its 15 bits
      s = '{FOCAL_X_RST, FOCAL_Y_RST, CENTER_COL_RST, CENTER_ROW_RST, 32'hFFFF_9000};
      case (phase)
         1: s = '{32'h0001_0000, 32'h0001_0000, 32'h0064_8000, 32'h0032_0000, 32'd1024};
         2: s = '{32'h012C_0000, 32'h0384_0000, 32'h0000_0000, 32'h0000_0000, 32'd16384};
         3: s = '{$urandom, $urandom, $urandom, $urandom, 32'h0000_0000};
         4: s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_7FFF};
         5: s = '{32'h0000_0000, 32'h0000_0000, 32'h03E8_0000, 32'h000C_4000, 32'd3000};
         6: s = '{$urandom_range(0, 32'h07D0_0000), $urandom_range(0, 32'h07D0_0000),
                   $urandom_range(0, 32'h0500_0000), $urandom_range(0, 32'h03C0_0000),
                   $urandom_range(1024, 16384)};
         7: s = '{$urandom, $urandom, $urandom, $urandom, $urandom};
         default: ;
      endcase
      return s;
   endfunction

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.point_x    <= '0;
      req_bus.point_y    <= '0;
      req_bus.point_z    <= '0;
      req_bus.last_point <= 1'b0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= '0;
      csr_bus.data       <= '0;
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      hold_rsp   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed points on the reset camera
      send_point(make_point(0, 0, Q_ONE, 1'b0));          // optical axis
      send_point(make_point(1, 1, 32'sd1056, 1'b0));      // exactly half a pixel, rounds up
      send_point(make_point(-1, -1, 32'sd1056, 1'b0));    // minus half a pixel
      send_point(make_point(Q_MAX, Q_MAX, 0, 1'b0));      // zero depth
      send_point(make_point(Q_MAX, Q_MAX, 1, 1'b0));      // saturated, clamp high
      send_point(make_point(Q_MIN, Q_MIN, 1, 1'b0));      // clamp low
      send_point(make_point(Q_MIN, Q_MAX, Q_MIN, 1'b0));
      send_point(make_point(Q_MAX, Q_MIN, Q_MAX, 1'b0));
      send_point(make_point(Q_ONE, -Q_ONE, -Q_ONE, 1'b0)); // behind the camera
      send_point(make_point(0, 0, Q_MIN, 1'b1));           // end of cloud
      send_point(make_point(Q_ONE, Q_ONE, 32'sh0002_0000, 1'b0));
      send_point(make_point(Q_MIN, Q_MIN, 0, 1'b1));       // zero depth ending a cloud
      send_point(make_point(0, 0, -1, 1'b1));
      send_point(make_point(-Q_ONE, Q_ONE, 32'sh0000_8000, 1'b0));
      send_point(make_point(32'sh0001_8000, -32'sh0000_4000, Q_ONE, 1'b0));
      end_burst();

      // Random points under a run of camera settings
      for (int phase = 0; phase < PHASES; phase++) begin
         apply_setting(pick_setting(phase));
         req_idling = (phase != 2 && phase != 5);
         rsp_idling = (phase != 2 && phase != 6);
         for (int n = 0; n < PHASE_POINTS; n++) begin
            if (phase == 1 && n == 30)
               hold_rsp = 1'b1;
            send_point(random_point());
         end
         end_burst();
      end

      repeat (50) @(posedge clock);
      if (board.failures == 0 && board.outstanding() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/ppp_pkg.sv
hw/rtl/ppp_if.sv
hw/rtl/ppp_ctrl.sv
hw/rtl/ppp_dp.sv
hw/rtl/point_to_pixel_projection.sv
hw/rtl/ppp_checker.sv
verif/point_to_pixel_projection_tb.sv
